>>> rtl/core/vbs_pkg.sv
// vbs_pkg: shared types, codes and the sine table builder for the
// vibration burst sequencer core. No dependencies.

package vbs_pkg;

  // fixed field widths
  localparam int CHAN_W   = 2;
  localparam int REPS_W   = 8;
  localparam int AMP_W    = 15;
  localparam int STEP_W   = 32;
  localparam int LEN_W    = 24;
  localparam int SAMPLE_W = 16;
  localparam int PSTATE_W = 2;

  // padded stream widths
  localparam int S_DATA_W = 104;
  localparam int M_DATA_W = 24;

  // request kinds on the input tuser
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // reported state codes
  localparam logic [PSTATE_W-1:0] PSTATE_IDLE   = 2'd0;
  localparam logic [PSTATE_W-1:0] PSTATE_RENDER = 2'd1;
  localparam logic [PSTATE_W-1:0] PSTATE_PAUSE  = 2'd2;

  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd1;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_RENDER = 3'b010,
    MODE_PAUSE  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [PSTATE_W-1:0]        phase_state;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
  } result_t;

  // sine entry k of a 2^index_bits table: bit 15 sign, bits 14:0 magnitude (Q15)
  function automatic logic [15:0] sine_entry(input longint unsigned k,
                                             input int unsigned index_bits);
    longint unsigned qb;
    longint unsigned quad;
    longint unsigned pos;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    longint unsigned mag;
    logic            neg;
    qb   = longint'(index_bits) - 2;
    quad = (k >> qb) & 3;
    pos  = k & ((longint'(1) << qb) - 1);
    x    = pos << (16 - qb);
    if (quad[0]) begin
      x = 65536 - x;
    end
    x2  = (x * x) >> 16;
    t   = 42047 - ((x2 * 4640) >> 16);
    t   = 102944 - ((x2 * t) >> 16);
    y   = (x * t) >> 16;
    mag = (y * 32767 + 32768) >> 16;
    if (mag > 32767) begin
      mag = 32767;
    end
    neg = quad[1] && (mag != 0);
    return {neg, mag[14:0]};
  endfunction

endpackage

>>> rtl/core/vibration_burst_sequencer_core.sv
// vibration_burst_sequencer_core: top level of the haptic sine burst sequencer.
// Depends on vbs_pkg for types, codes and the sine table builder.

// Streams sine bursts for a haptic actuator. Two kinds of transaction come in on
// the s_ side, chosen by s_tuser: a trigger (1) loads repetitions, amplitude,
// phase step, render length and pause length and latches a pending start; it
// yields no output. A tick (0) runs the idle/render/pause machine and yields one
// output transaction: the channel in m_tuser, and in m_tdata the sample
// (amplitude times sine while rendering, else zero, taken before the state
// update) plus the state after the tick. A burst lasts render_ticks ticks
// (at least one), with a pause of pause_ticks ticks (at least one) between
// bursts, for the given number of bursts (0 counts as 1). A trigger during a run
// updates the running settings at once and starts a fresh run once this one
// ends. The block takes one transaction per clock cycle while the skid stage is
// empty. The sine table is a ROM of 2^SINE_INDEX_BITS entries registered from
// the phase accumulator's next value, and the sample path is one 15x15 multiply
// with rounding. An output register plus a one-entry skid stage let input keep
// flowing while a result waits; s_tready drops only while the skid stage is
// occupied. No clearing pass is needed after reset.

module vibration_burst_sequencer_core
  import vbs_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_INDEX_BITS = 10,
  parameter int TIMER_BITS      = 24
) (
  input  logic                clk,
  input  logic                rst,
  // configuration: output channel
  input  logic                cfg_wen,
  input  logic [CHAN_W-1:0]   cfg_wdata,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // repetitions[7:0], amplitude[22:8], phase_step[54:23], render_ticks[78:55],
  // pause_ticks[102:79], zero pad[103]
  input  logic [S_DATA_W-1:0] s_tdata,
  // req_type[0]
  input  logic                s_tuser,
  // output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // sample[15:0], phase_state[17:16], zero pad[23:18]
  output logic [M_DATA_W-1:0] m_tdata,
  // channel[1:0]
  output logic [CHAN_W-1:0]   m_tuser
);

  localparam int SINE_DEPTH = 2 ** SINE_INDEX_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  typedef logic [15:0] rom_t [SINE_DEPTH];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(longint'(k), SINE_INDEX_BITS);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // input fields
  logic [REPS_W-1:0] in_reps;
  logic [AMP_W-1:0]  in_amp;
  logic [STEP_W-1:0] in_step;
  logic [LEN_W-1:0]  in_render;
  logic [LEN_W-1:0]  in_pause;

  assign in_reps   = s_tdata[7:0];
  assign in_amp    = s_tdata[22:8];
  assign in_step   = s_tdata[54:23];
  assign in_render = s_tdata[78:55];
  assign in_pause  = s_tdata[102:79];

  // state
  logic [CHAN_W-1:0]     output_channel;
  mode_t                 mode, mode_next;
  logic                  pending, pending_next;
  logic [TIMER_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [REPS_W-1:0]     reps_left, reps_left_next;
  logic [AMP_W-1:0]      amp_held;
  logic [PHASE_BITS-1:0] step_held;
  logic [TIMER_BITS-1:0] render_len;
  logic [TIMER_BITS-1:0] pause_len;
  logic [PHASE_BITS-1:0] phase_acc, phase_acc_next;

  // sine rom read register, always holds the entry for the current phase_acc
  logic [SINE_INDEX_BITS-1:0] rom_addr;
  logic [15:0]                sine_q;

  // output side
  result_t res;
  result_t out_q, skid_q;
  logic    skid_valid;
  logic    out_free;

  logic tick_acc, trig_acc;

  assign s_tready = !skid_valid;
  assign tick_acc = s_tvalid && s_tready && (s_tuser == REQ_TICK);
  assign trig_acc = s_tvalid && s_tready && (s_tuser == REQ_TRIGGER);
  assign out_free = !m_tvalid || m_tready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_channel <= CHAN_RESET;
    end else if (cfg_wen) begin
      output_channel <= cfg_wdata;
    end
  end

  // phase accumulator advances on every tick in every mode
  assign phase_acc_next = tick_acc ? phase_acc + step_held : phase_acc;
  assign rom_addr = rst ? '0 : phase_acc_next[PHASE_BITS-1 -: SINE_INDEX_BITS];

  always_ff @(posedge clk) begin
    sine_q <= SINE_ROM[rom_addr];
  end

  // sample: round(amp * |sine| / 2^15), then sign; zero outside render
  logic [AMP_W+AMP_W-1:0] prod;
  logic [AMP_W-1:0]       mag;
  logic [SAMPLE_W-1:0]    sample_mag;
  logic signed [SAMPLE_W-1:0] sample;

  always_comb begin
    prod       = amp_held * sine_q[14:0] + (AMP_W + AMP_W)'(16384);
    mag        = prod[AMP_W+AMP_W-1:AMP_W];
    sample_mag = {1'b0, mag};
    if (mode != MODE_RENDER) begin
      sample = '0;
    end else if (sine_q[15]) begin
      sample = -sample_mag;
    end else begin
      sample = sample_mag;
    end
  end

  // state machine for one tick
  assign elapsed_inc = (elapsed == TIMER_MAX) ? elapsed : elapsed + 1'b1;

  always_comb begin
    mode_next      = mode;
    pending_next   = pending;
    elapsed_next   = elapsed;
    reps_left_next = reps_left;
    case (mode)
      MODE_RENDER: begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= render_len) begin
          if (reps_left <= REPS_W'(1)) begin
            reps_left_next = '0;
            mode_next      = MODE_IDLE;
          end else begin
            reps_left_next = reps_left - 1'b1;
            mode_next      = MODE_PAUSE;
            elapsed_next   = '0;
          end
        end
      end
      MODE_PAUSE: begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= pause_len) begin
          mode_next    = MODE_RENDER;
          elapsed_next = '0;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (pending) begin
          pending_next = 1'b0;
          mode_next    = MODE_RENDER;
          elapsed_next = '0;
        end
      end
    endcase
  end

  always_comb begin
    res.channel = output_channel;
    res.sample  = sample;
    case (mode_next)
      MODE_RENDER: res.phase_state = PSTATE_RENDER;
      MODE_PAUSE:  res.phase_state = PSTATE_PAUSE;
      default:     res.phase_state = PSTATE_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pending   <= 1'b0;
      elapsed   <= '0;
      reps_left <= '0;
      step_held <= '0;
      phase_acc <= '0;
    end else begin
      phase_acc <= phase_acc_next;
      if (trig_acc) begin
        reps_left <= (in_reps == '0) ? REPS_W'(1) : in_reps;
        step_held <= PHASE_BITS'(in_step);
        pending   <= 1'b1;
      end else if (tick_acc) begin
        mode      <= mode_next;
        pending   <= pending_next;
        elapsed   <= elapsed_next;
        reps_left <= reps_left_next;
      end
    end
  end

  // burst settings, only read after a trigger has loaded them
  always_ff @(posedge clk) begin
    if (trig_acc) begin
      amp_held   <= in_amp;
      render_len <= ((in_render >> TIMER_BITS) != '0) ? TIMER_MAX : TIMER_BITS'(in_render);
      pause_len  <= ((in_pause >> TIMER_BITS) != '0) ? TIMER_MAX : TIMER_BITS'(in_pause);
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= tick_acc;
      end
    end else if (tick_acc) begin
      skid_valid <= 1'b1;
    end
  end

  // output register and skid stage payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (tick_acc) begin
      skid_q <= res;
    end
  end

  assign m_tuser = out_q.channel;
  assign m_tdata = {{(M_DATA_W - SAMPLE_W - PSTATE_W){1'b0}}, out_q.phase_state, out_q.sample};

  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage valid without output valid");

  // a trigger always leaves a start pending
  a_trigger_pends: assert property (@(posedge clk) disable iff (rst)
    trig_acc |=> pending)
    else $error("trigger did not latch a pending start");

  // a pause always has at least one burst left to run
  a_pause_has_reps: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_PAUSE) |-> (reps_left != '0))
    else $error("pause with no bursts left");

  // every burst starts with a cleared timer
  a_render_starts_clear: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_RENDER) && ($past(mode) != MODE_RENDER)) |-> (elapsed == '0))
    else $error("render entered with nonzero elapsed count");

endmodule

>>> test/vbs_burst_check_pkg.sv
`timescale 1ns / 1ps
// vbs_burst_check_pkg: scoreboard class for the vibration burst sequencer test,
// a bit-true predictor of the tick machine plus the queue of expected samples.
// Depends on vbs_pkg for the request kinds and state codes.

package vbs_burst_check_pkg;
  import vbs_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic [PSTATE_W-1:0] pstate;
  } tick_sample_t;

  class burst_scoreboard;
    localparam int LUT_BITS = 10;
    localparam int unsigned TICK_MAX = 32'h00FF_FFFF;

    int          sine_lut [1 << LUT_BITS];
    tick_sample_t sample_q [$];

    // predicted block state
    logic [CHAN_W-1:0]   chan;
    logic [PSTATE_W-1:0] mode;
    bit                  pending;
    int unsigned         elapsed;
    int unsigned         reps_left;
    int unsigned         amp_hold;
    bit [31:0]           step_hold;
    int unsigned         render_len;
    int unsigned         pause_len;
    bit [31:0]           phase_acc;

    int mismatches;
    int n_ticks;
    int n_triggers;
    int n_checked;
    int n_nonzero;
    int n_pause;

    function new();
      longint unsigned quad;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      longint unsigned mag;
      // quarter-wave polynomial, Q16 coefficients, magnitude rounded to Q15
      for (int k = 0; k < (1 << LUT_BITS); k++) begin
        quad = longint'((k >> (LUT_BITS - 2)) & 3);
        x = longint'(k & ((1 << (LUT_BITS - 2)) - 1)) << (16 - (LUT_BITS - 2));
        if (quad[0]) begin
          x = 65536 - x;
        end
        x2  = (x * x) >> 16;
        t   = 42047 - ((x2 * 4640) >> 16);
        t   = 102944 - ((x2 * t) >> 16);
        y   = (x * t) >> 16;
        mag = (y * 32767 + 32768) >> 16;
        if (mag > 32767) begin
          mag = 32767;
        end
        sine_lut[k] = quad[1] ? -int'(mag) : int'(mag);
      end
      chan       = CHAN_RESET;
      mode       = PSTATE_IDLE;
      pending    = 1'b0;
      elapsed    = 0;
      reps_left  = 0;
      amp_hold   = 0;
      step_hold  = '0;
      render_len = 0;
      pause_len  = 0;
      phase_acc  = '0;
      mismatches = 0;
      n_ticks    = 0;
      n_triggers = 0;
      n_checked  = 0;
      n_nonzero  = 0;
      n_pause    = 0;
    endfunction

    function void set_channel(logic [CHAN_W-1:0] value);
      chan = value;
    endfunction

    function int outstanding();
      return sample_q.size();
    endfunction

    // one accepted input transaction: a trigger loads settings, a tick predicts a sample
    function void note_item(logic req, logic [REPS_W-1:0] reps, logic [AMP_W-1:0] amp,
                            logic [STEP_W-1:0] step, logic [LEN_W-1:0] rlen,
                            logic [LEN_W-1:0] plen);
      tick_sample_t exp_s;
      int           sv;
      bit [31:0]    mag;
      if (req == REQ_TRIGGER) begin
        reps_left  = (reps == 0) ? 1 : 32'(reps);
        amp_hold   = 32'(amp);
        step_hold  = step;
        render_len = 32'(rlen);
        pause_len  = 32'(plen);
        pending    = 1'b1;
        n_triggers++;
        return;
      end
      n_ticks++;
      exp_s.sample = '0;
      if (mode == PSTATE_RENDER) begin
        sv  = sine_lut[phase_acc[31 -: LUT_BITS]];
        mag = (amp_hold * int'((sv < 0) ? -sv : sv) + 16384) >> 15;
        if (mag > 32767) begin
          mag = 32767;
        end
        exp_s.sample = mag[SAMPLE_W-1:0];
        if (sv < 0) begin
          exp_s.sample = -exp_s.sample;
        end
      end
      exp_s.channel = chan;
      phase_acc = phase_acc + step_hold;
      case (mode)
        PSTATE_RENDER: begin
          if (elapsed < TICK_MAX) begin
            elapsed++;
          end
          if (elapsed >= render_len) begin
            if (reps_left <= 1) begin
              reps_left = 0;
              mode = PSTATE_IDLE;
            end else begin
              reps_left--;
              mode = PSTATE_PAUSE;
              elapsed = 0;
            end
          end
        end
        PSTATE_PAUSE: begin
          if (elapsed < TICK_MAX) begin
            elapsed++;
          end
          if (elapsed >= pause_len) begin
            mode = PSTATE_RENDER;
            elapsed = 0;
          end
        end
        default: begin
          mode = PSTATE_IDLE;
          if (pending) begin
            pending = 1'b0;
            mode = PSTATE_RENDER;
            elapsed = 0;
          end
        end
      endcase
      exp_s.pstate = mode;
      sample_q.push_back(exp_s);
    endfunction

    function void check_result(logic [CHAN_W-1:0] channel, logic [SAMPLE_W-1:0] sample,
                               logic [PSTATE_W-1:0] pstate);
      tick_sample_t exp_s;
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output: chan %0d sample %0d state %0d",
                   channel, $signed(sample), pstate);
        end
        return;
      end
      exp_s = sample_q.pop_front();
      n_checked++;
      if (exp_s.sample != 0) begin
        n_nonzero++;
      end
      if (exp_s.pstate == PSTATE_PAUSE) begin
        n_pause++;
      end
      if (exp_s.channel !== channel || exp_s.sample !== sample || exp_s.pstate !== pstate) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at output %0d: chan exp %0d got %0d,", n_checked,
                   exp_s.channel, channel,
                   " sample exp %0d got %0d, state exp %0d got %0d",
                   $signed(exp_s.sample), $signed(sample), exp_s.pstate, pstate);
        end
      end
    endfunction
  endclass

endpackage

>>> test/vibration_burst_sequencer_core_test.sv
`timescale 1ns / 1ps
// vibration_burst_sequencer_core_test: self-checking test of the burst sequencer core,
// random tick/trigger streams with bursty input and stalling output, checked per sample.
// Depends on vbs_pkg and vbs_burst_check_pkg.

module vibration_burst_sequencer_core_test;
  import vbs_pkg::*;
  import vbs_burst_check_pkg::*;

  localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction before giving up
  localparam int SETTLE_CYCLES = 8;     // covers the core's pipeline after the last result
  localparam int HOLD_CYCLES   = 60;    // long output stall used to back the core up
  localparam int PHASE_ITEMS   = 90;

  typedef struct {
    logic              req;
    logic [REPS_W-1:0] reps;
    logic [AMP_W-1:0]  amp;
    logic [STEP_W-1:0] step;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  plen;
  } burst_item_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_wen   = 1'b0;
  logic [CHAN_W-1:0]   cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [CHAN_W-1:0]   m_tuser;

  burst_scoreboard sb = new();

  int  quiet_cycles = 0;
  int  burst_left   = 0;
  int  items_sent   = 0;
  int  n_settings   = 1;
  bit  hold_req     = 1'b0;

  vibration_burst_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor: check the output transaction first, then note the input one,
  // so a tick taken on this edge never pairs with a sample leaving on it
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tuser, m_tdata[15:0], m_tdata[17:16]);
      end
      if (s_tvalid && s_tready) begin
        sb.note_item(s_tuser, s_tdata[7:0], s_tdata[22:8], s_tdata[54:23],
                     s_tdata[78:55], s_tdata[102:79]);
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog on stalled traffic
  initial begin
    @(negedge rst);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // output side: ready pattern with its own duty cycle, plus the long hold on request
  initial begin
    int ready_pct;
    int pattern_left;
    int hold_cnt;
    ready_pct = 100;
    pattern_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 35;
            default: ready_pct = 90;
          endcase
          pattern_left = $urandom_range(20, 80);
        end
        pattern_left--;
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // input side: one transaction, sent in bursts with random gaps between them
  task automatic send_item(input burst_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 32);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req;
    s_tdata  <= {1'b0, it.plen, it.rlen, it.step, it.amp, it.reps};
    do begin
      @(posedge clk);
    end while (!s_tready);
    burst_left--;
    items_sent++;
  endtask

  // ticks carry random payload bits, which the core must ignore
  task automatic send_ticks(input int count);
    burst_item_t it;
    for (int i = 0; i < count; i++) begin
      it.req  = REQ_TICK;
      it.reps = REPS_W'($urandom);
      it.amp  = AMP_W'($urandom);
      it.step = $urandom;
      it.rlen = LEN_W'($urandom);
      it.plen = LEN_W'($urandom);
      send_item(it);
    end
  endtask

  task automatic send_trigger(input logic [REPS_W-1:0] reps, input logic [AMP_W-1:0] amp,
                              input logic [STEP_W-1:0] step, input logic [LEN_W-1:0] rlen,
                              input logic [LEN_W-1:0] plen);
    burst_item_t it;
    it.req  = REQ_TRIGGER;
    it.reps = reps;
    it.amp  = amp;
    it.step = step;
    it.rlen = rlen;
    it.plen = plen;
    send_item(it);
  endtask

  // stop offering, wait for every predicted sample, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel(input logic [CHAN_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_channel(value);
    cfg_wen   <= 1'b0;
    n_settings++;
  endtask

  // mostly short lengths so runs finish, sometimes extremes or full-range values
  function automatic logic [LEN_W-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      return LEN_W'($urandom_range(0, 5));
    end else if (roll == 8) begin
      return {LEN_W{1'b1}};
    end
    return LEN_W'($urandom);
  endfunction

  // one random sequence: a well-formed run, a retrigger in flight, or noise
  task automatic random_sequence();
    logic [REPS_W-1:0] reps;
    logic [AMP_W-1:0]  amp;
    logic [STEP_W-1:0] step;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  plen;
    int                kind;
    longint            run_len;
    kind = $urandom_range(0, 99);
    reps = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    case ($urandom_range(0, 5))
      0: amp = '1;
      1: amp = '0;
      default: amp = AMP_W'($urandom);
    endcase
    step = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 65535) << 12) : $urandom;
    rlen = pick_len();
    plen = pick_len();
    if (kind < 70) begin
      send_trigger(reps, amp, step, rlen, plen);
      run_len = longint'((reps == 0) ? 1 : reps) *
                ((rlen == 0 ? 1 : rlen) + (plen == 0 ? 1 : plen)) + 2;
      if (run_len <= 40) begin
        send_ticks(int'(run_len) + $urandom_range(0, 3));
      end else begin
        // cut a long run short with a one-tick burst
        send_ticks($urandom_range(5, 25));
        send_trigger(8'd1, AMP_W'($urandom), $urandom, '0, '0);
        send_ticks(4);
      end
    end else if (kind < 85) begin
      send_trigger(reps, amp, step, rlen, plen);
      send_ticks($urandom_range(1, 5));
      send_trigger(8'($urandom_range(0, 2)), AMP_W'($urandom), $urandom,
                   24'($urandom_range(0, 3)), 24'($urandom_range(0, 3)));
      send_ticks($urandom_range(4, 12));
    end else if (kind < 95) begin
      send_ticks($urandom_range(1, 8));
    end else begin
      send_trigger(reps, amp, step, rlen, plen);
    end
  endtask

  task automatic random_phase(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      random_sequence();
    end
  endtask

  initial begin
    logic [CHAN_W-1:0] rand_chan;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part on the reset channel
    send_ticks(1);                                          // idle tick gives zero
    send_trigger(8'd0, '1, '1, '0, '0);                     // zero reps, zero lengths
    send_ticks(3);
    send_trigger(8'd2, '1, 32'h0100_0000, 24'd2, '0);       // two bursts, zero pause
    send_ticks(8);
    send_trigger('1, '0, '0, '1, '1);                       // extreme reps and lengths
    send_ticks(2);
    send_trigger(8'd1, 15'd16384, 32'h0400_0000, 24'd1, 24'd1);  // retrigger while busy
    send_ticks(4);
    random_phase(PHASE_ITEMS - 22);
    drain();

    write_channel(2'd0);
    random_phase(PHASE_ITEMS);
    drain();

    write_channel(2'd3);
    // back the core up: long output hold while ticks keep coming
    hold_req = 1'b1;
    send_ticks(30);
    random_phase(PHASE_ITEMS - 30);
    drain();

    write_channel(2'd2);
    random_phase(PHASE_ITEMS / 2);
    drain();                                                // sender waits out every sample
    random_phase(PHASE_ITEMS / 2);
    drain();

    rand_chan = CHAN_W'($urandom);
    write_channel(rand_chan);
    random_phase(PHASE_ITEMS);
    drain();

    $display("covered %0d ticks and %0d triggers over %0d channel settings",
             sb.n_ticks, sb.n_triggers, n_settings);
    $display("checked %0d samples: %0d nonzero, %0d in pause, %0d mismatches",
             sb.n_checked, sb.n_nonzero, sb.n_pause, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
